[design/i2cmap_pkg.sv]
// Shared types and constants for the I2C target register map.
// No dependencies; imported by i2cmap_store and i2c_target_register_map_unit.
`default_nettype none

package i2cmap_pkg;

  // bus / local event codes
  localparam logic [2:0] MODE_MATCH_WR = 3'd0;
  localparam logic [2:0] MODE_MATCH_RD = 3'd1;
  localparam logic [2:0] MODE_RX       = 3'd2;
  localparam logic [2:0] MODE_TX       = 3'd3;
  localparam logic [2:0] MODE_STOP     = 3'd4;
  localparam logic [2:0] MODE_ERROR    = 3'd5;
  localparam logic [2:0] MODE_LOC_WR   = 3'd6;
  localparam logic [2:0] MODE_LOC_RD   = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_UNLOCK_KEY  = 3'd0;
  localparam logic [2:0] CFG_ENABLE_ADDR = 3'd1;
  localparam logic [2:0] CFG_FILTER_ADDR = 3'd2;
  localparam logic [2:0] CFG_COEF_A_BASE = 3'd3;
  localparam logic [2:0] CFG_COEF_B_BASE = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_UNLOCK_KEY  = 8'hA5;
  localparam logic [6:0] RST_ENABLE_ADDR = 7'h4C;
  localparam logic [6:0] RST_FILTER_ADDR = 7'h4D;
  localparam logic [6:0] RST_COEF_A_BASE = 7'h50;
  localparam logic [6:0] RST_COEF_B_BASE = 7'h54;

  // fixed map locations and fill value
  localparam logic [7:0] KEY_ADDR     = 8'h04;
  localparam logic [7:0] NEWADDR_ADDR = 8'h05;
  localparam logic [7:0] STATUS2_ADDR = 8'h29;
  localparam logic [7:0] FILL_BYTE    = 8'hFF;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic [6:0] local_addr;
  } req_t;

  typedef struct packed {
    logic [7:0] result_data;
    logic       busy_res;
    logic       config_update;
    logic       coef_update;
    logic       address_change;
    logic [6:0] new_address;
  } rsp_t;

endpackage

`default_nettype wire

[design/i2cmap_store.sv]
// Register map byte store: one write port, one registered read port, and a
// valid bit per entry so unwritten bytes read as zero after reset.
// Uses i2cmap_pkg.
`default_nettype none

module i2cmap_store #(
  parameter int Depth = 128,
  parameter int Aw    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [Aw-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [Aw-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import i2cmap_pkg::*;

  logic [7:0]       map_mem [Depth];
  logic [Depth-1:0] map_vld;
  logic [7:0]       rd_mem;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= map_vld[rd_addr];
      end
      if (wr_en) begin
        map_vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_mem : ZERO_BYTE;

endmodule

`default_nettype wire

[design/i2c_target_register_map_unit.sv]
// Top level of the I2C target register map: event decode, pointer and flag
// state, key/new-address shadows, result staging. Uses i2cmap_pkg, i2cmap_store.
//
// Usage:
//   Request channel (in_valid/in_ready/in_req) carries one bus or local event:
//   address match, received byte, transmit request, stop, error, local write
//   or local read. Every request yields exactly one response on the response
//   channel (out_valid/out_ready/out_rsp).
//   Throughput: one request per cycle while the pending stage can advance.
//   The map is a synchronous memory with a registered read; a response
//   passes the pending stage (map access), then the output register.
//   Back-to-back accesses to one byte need no interlock: the write of a
//   request lands at its accept edge, before the next request's read.
//   A pending stage and the output register decouple the two sides; when the
//   receiver stalls, at most two responses wait and in_ready drops until the
//   pending stage can advance.
//   Reset (rst, synchronous): map reads as all zeros (per-byte valid bits),
//   pointer 0, address phase set, flags clear, configuration registers at
//   their defaults. The user must write the configuration port (cfg_wen/
//   cfg_idx/cfg_wdata) only while no request is in flight (the block does not check).
`default_nettype none

module i2c_target_register_map_unit #(
  parameter int MAP_BYTES  = 128,
  parameter int NAME_BASE  = 24,
  parameter int NAME_LEN   = 16,
  parameter int EXT_BASE   = 76,
  parameter int COEF_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cmap_pkg::req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cmap_pkg::rsp_t  out_rsp,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_idx,
  input  logic [7:0]        cfg_wdata
);
  import i2cmap_pkg::*;

  localparam int AW = $clog2(MAP_BYTES);
  localparam logic [8:0] MAP_LIM   = 9'(MAP_BYTES);
  localparam logic [8:0] NAME_LO   = 9'(NAME_BASE);
  localparam logic [8:0] NAME_HI   = 9'(NAME_BASE + NAME_LEN);
  localparam logic [8:0] EXT_LO    = 9'(EXT_BASE);
  localparam logic [8:0] COEF_SPAN = 9'(COEF_BYTES);

  // configuration
  logic [7:0] unlock_key;
  logic [6:0] enable_addr;
  logic [6:0] filter_addr;
  logic [6:0] coef_a_base;
  logic [6:0] coef_b_base;

  // transaction state
  logic [7:0] map_ptr, map_ptr_next;
  logic       addr_phase, addr_phase_next;
  logic       cfg_written, cfg_written_next;
  logic       coef_written, coef_written_next;
  logic       addr_written, addr_written_next;
  logic       busy_flag, busy_flag_next;
  logic [7:0] key_byte, key_byte_next;
  logic [7:0] naddr_byte, naddr_byte_next;

  // pending stage
  logic       pend_valid;
  logic       pend_rsel;
  rsp_t       pend_rsp;
  rsp_t       pend_out;
  rsp_t       stage_rsp;
  logic       stage_rsel;
  logic       accept;
  logic       pend_move;

  // map port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [8:0] ptr9;
  logic [8:0] data9;
  logic [8:0] laddr9;
  logic [8:0] coef_a9;
  logic [8:0] coef_b9;
  logic       in_name;
  logic       wr_ok;
  logic       is_cfg;
  logic       is_coef;

  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign in_ready  = !pend_valid || pend_move;
  assign accept    = in_valid && in_ready;

  assign ptr9    = {1'b0, map_ptr};
  assign data9   = {1'b0, in_req.data_byte};
  assign laddr9  = {2'b00, in_req.local_addr};
  assign coef_a9 = {2'b00, coef_a_base};
  assign coef_b9 = {2'b00, coef_b_base};

  assign in_name = (ptr9 >= NAME_LO) && (ptr9 < NAME_HI);

  always_comb begin
    wr_ok = 1'b0;
    if (ptr9 < MAP_LIM) begin
      priority if (map_ptr == KEY_ADDR) begin
        wr_ok = 1'b1;
      end else if (map_ptr == NEWADDR_ADDR) begin
        wr_ok = (key_byte == unlock_key);
      end else if (in_name || map_ptr == STATUS2_ADDR || ptr9 >= EXT_LO) begin
        wr_ok = 1'b1;
      end else begin
        wr_ok = 1'b0;
      end
    end
  end

  assign is_cfg = in_name || (map_ptr == {1'b0, enable_addr}) ||
                  (map_ptr == {1'b0, filter_addr});
  assign is_coef = ((ptr9 >= coef_a9) && (ptr9 < coef_a9 + COEF_SPAN)) ||
                   ((ptr9 >= coef_b9) && (ptr9 < coef_b9 + COEF_SPAN));

  always_comb begin
    map_ptr_next      = map_ptr;
    addr_phase_next   = addr_phase;
    cfg_written_next  = cfg_written;
    coef_written_next = coef_written;
    addr_written_next = addr_written;
    busy_flag_next    = busy_flag;
    key_byte_next     = key_byte;
    naddr_byte_next   = naddr_byte;
    mem_we            = 1'b0;
    mem_waddr         = map_ptr[AW-1:0];
    mem_wdata         = in_req.data_byte;
    mem_re            = 1'b0;
    mem_raddr         = map_ptr[AW-1:0];
    stage_rsel        = 1'b0;
    stage_rsp         = '0;
    unique case (in_req.mode)
      MODE_MATCH_WR: begin
        busy_flag_next    = 1'b1;
        addr_phase_next   = 1'b1;
        cfg_written_next  = 1'b0;
        coef_written_next = 1'b0;
        addr_written_next = 1'b0;
      end
      MODE_MATCH_RD: begin
        busy_flag_next = 1'b1;
      end
      MODE_RX: begin
        if (addr_phase) begin
          map_ptr_next    = (data9 >= MAP_LIM) ? ZERO_BYTE : in_req.data_byte;
          addr_phase_next = 1'b0;
        end else begin
          if (wr_ok) begin
            mem_we = 1'b1;
            if (map_ptr == KEY_ADDR) begin
              key_byte_next = in_req.data_byte;
            end
            if (map_ptr == NEWADDR_ADDR) begin
              naddr_byte_next   = in_req.data_byte;
              addr_written_next = 1'b1;
            end
            if (is_cfg) begin
              cfg_written_next = 1'b1;
            end
            if (is_coef) begin
              coef_written_next = 1'b1;
            end
          end
          map_ptr_next = map_ptr + 8'd1;
        end
      end
      MODE_TX: begin
        if (ptr9 < MAP_LIM) begin
          mem_re       = 1'b1;
          stage_rsel   = 1'b1;
          map_ptr_next = map_ptr + 8'd1;
        end else begin
          stage_rsp.result_data = FILL_BYTE;
        end
      end
      MODE_STOP, MODE_ERROR: begin
        if (in_req.mode == MODE_STOP) begin
          if (addr_written && key_byte == unlock_key) begin
            stage_rsp.address_change = 1'b1;
            stage_rsp.new_address    = naddr_byte[6:0];
          end
          key_byte_next = ZERO_BYTE;
          mem_we        = 1'b1;
          mem_waddr     = KEY_ADDR[AW-1:0];
          mem_wdata     = ZERO_BYTE;
        end
        busy_flag_next          = 1'b0;
        stage_rsp.config_update = cfg_written;
        stage_rsp.coef_update   = coef_written;
        cfg_written_next        = 1'b0;
        coef_written_next       = 1'b0;
        addr_written_next       = 1'b0;
      end
      MODE_LOC_WR: begin
        mem_waddr = AW'(in_req.local_addr);
        if (laddr9 < MAP_LIM) begin
          mem_we = 1'b1;
          if ({1'b0, in_req.local_addr} == KEY_ADDR) begin
            key_byte_next = in_req.data_byte;
          end
          if ({1'b0, in_req.local_addr} == NEWADDR_ADDR) begin
            naddr_byte_next = in_req.data_byte;
          end
        end
      end
      MODE_LOC_RD: begin
        mem_raddr = AW'(in_req.local_addr);
        if (laddr9 < MAP_LIM) begin
          mem_re     = 1'b1;
          stage_rsel = 1'b1;
        end else begin
          stage_rsp.result_data = FILL_BYTE;
        end
      end
    endcase
    stage_rsp.busy_res = busy_flag_next;
    if (!accept) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  i2cmap_store #(
    .Depth(MAP_BYTES),
    .Aw   (AW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_key  <= RST_UNLOCK_KEY;
      enable_addr <= RST_ENABLE_ADDR;
      filter_addr <= RST_FILTER_ADDR;
      coef_a_base <= RST_COEF_A_BASE;
      coef_b_base <= RST_COEF_B_BASE;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        CFG_UNLOCK_KEY:  unlock_key  <= cfg_wdata;
        CFG_ENABLE_ADDR: enable_addr <= cfg_wdata[6:0];
        CFG_FILTER_ADDR: filter_addr <= cfg_wdata[6:0];
        CFG_COEF_A_BASE: coef_a_base <= cfg_wdata[6:0];
        CFG_COEF_B_BASE: coef_b_base <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_ptr      <= ZERO_BYTE;
      addr_phase   <= 1'b1;
      cfg_written  <= 1'b0;
      coef_written <= 1'b0;
      addr_written <= 1'b0;
      busy_flag    <= 1'b0;
      key_byte     <= ZERO_BYTE;
      naddr_byte   <= ZERO_BYTE;
    end else if (accept) begin
      map_ptr      <= map_ptr_next;
      addr_phase   <= addr_phase_next;
      cfg_written  <= cfg_written_next;
      coef_written <= coef_written_next;
      addr_written <= addr_written_next;
      busy_flag    <= busy_flag_next;
      key_byte     <= key_byte_next;
      naddr_byte   <= naddr_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    pend_out = pend_rsp;
    if (pend_rsel) begin
      pend_out.result_data = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rsp  <= stage_rsp;
      pend_rsel <= stage_rsel;
    end
    if (pend_move) begin
      out_rsp <= pend_out;
    end
  end

  // a pending response never vanishes while the output side is stalled
  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_move |=> pend_valid)
    else $error("pending response lost");

  // an address change only happens at stop, which ends the transaction
  a_achg_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_rsp.address_change && out_rsp.busy_res))
    else $error("address change while busy");

  // new_address is only driven with an address change
  a_naddr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.address_change |-> out_rsp.new_address == 7'd0)
    else $error("new address without change");

  // stop always clears the key shadow
  a_stop_key: assert property (@(posedge clk) disable iff (rst)
    accept && in_req.mode == MODE_STOP |=> key_byte == ZERO_BYTE)
    else $error("key not cleared at stop");

  // a write match re-arms the pointer phase
  a_match_phase: assert property (@(posedge clk) disable iff (rst)
    accept && in_req.mode == MODE_MATCH_WR |=> addr_phase && busy_flag)
    else $error("write match did not re-arm");

endmodule

`default_nettype wire
